>>> rtl/vspa_pkg.sv
// ----------------------------------------------------------------------------
// vspa_pkg: shared types and constants of the primitive assembler
// Command codes, draw modes, record kinds, item and job structs.
// ----------------------------------------------------------------------------
package vspa_pkg;

  localparam int INDEX_WIDTH = 16;
  localparam int JOBQ_DEPTH  = 2;
  localparam int JOBQ_AW     = $clog2(JOBQ_DEPTH);

  typedef logic [INDEX_WIDTH-1:0] idx_t;

  localparam idx_t IDX_ONE = idx_t'(1);
  localparam idx_t IDX_TWO = idx_t'(2);

  localparam logic [2:0] CMD_VERTEX   = 3'd0;
  localparam logic [2:0] CMD_BEGIN_FN = 3'd1;
  localparam logic [2:0] CMD_BEGIN_ST = 3'd2;
  localparam logic [2:0] CMD_BEGIN_LS = 3'd3;
  localparam logic [2:0] CMD_CLOSE    = 3'd4;
  localparam logic [2:0] CMD_LINE     = 3'd5;
  localparam logic [2:0] CMD_RECT     = 3'd6;
  localparam logic [2:0] CMD_QUAD     = 3'd7;

  localparam logic [1:0] KIND_TRI_VTX  = 2'd0;
  localparam logic [1:0] KIND_TRI_IDX  = 2'd1;
  localparam logic [1:0] KIND_LINE_VTX = 2'd2;
  localparam logic [1:0] KIND_LINE_IDX = 2'd3;

  typedef enum logic [3:0] {
    MODE_DEFAULT = 4'b0001,
    MODE_FAN     = 4'b0010,
    MODE_STRIP   = 4'b0100,
    MODE_LSTRIP  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic        [31:0] colour;
    logic        [31:0] colour_end;
    logic               two_colour;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [31:0] vert_colour;
    logic        [15:0] index_value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [31:0] colour;
  } vertex_t;

  // One command's worth of records: vertices first, then indices.
  typedef struct packed {
    logic                is_line;
    logic [2:0]          nv;
    logic [3:0]          ni;
    logic [15:0]         base;
    vertex_t [3:0]       vert;
    logic [7:0][15:0]    idx;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jobq_stat_t;

  function automatic logic [15:0] lo16(idx_t v);
    return v[15:0];
  endfunction

endpackage

>>> rtl/vspa_front.sv
// ----------------------------------------------------------------------------
// vspa_front: command decode and primitive state
// Tracks mode, vertex counts and list totals; emits up to one job per command.
// ----------------------------------------------------------------------------
module vspa_front import vspa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     job_vld,
  output job_t     job
);

  mode_t          mode_r, mode_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  vertex_t [1:0]  held_r, held_nxt;
  idx_t           ip0_r, ip0_nxt, ip1_r, ip1_nxt;
  idx_t           tri_tot_r, tri_tot_nxt, line_tot_r, line_tot_nxt;

  vertex_t            v;
  idx_t               p0, p1, adv, tb, lb;
  logic               sel, eqx, eqy;
  logic signed [15:0] xr, yb;
  logic [31:0]        c_end;

  always_comb begin
    v     = '{x: item.x, y: item.y, colour: item.colour};
    xr    = item.x_end + 16'sd1;
    yb    = item.y_end + 16'sd1;
    eqx   = (item.x == item.x_end);
    eqy   = (item.y == item.y_end);
    c_end = item.two_colour ? item.colour_end : item.colour;
    tb    = tri_tot_r;
    lb    = line_tot_r;
    p0    = ip0_r;
    p1    = ip1_r;
    adv   = '0;
    sel   = 1'b0;

    mode_nxt     = mode_r;
    cnt_nxt      = cnt_r;
    held_nxt     = held_r;
    ip0_nxt      = ip0_r;
    ip1_nxt      = ip1_r;
    tri_tot_nxt  = tri_tot_r;
    line_tot_nxt = line_tot_r;
    job          = '0;
    job_vld      = 1'b0;

    unique case (item.cmd)
      CMD_VERTEX: begin
        if (cnt_r != 2'd3) cnt_nxt = cnt_r + 2'd1;
        if (mode_r == MODE_FAN || mode_r == MODE_STRIP) begin
          if (cnt_r < 2'd2) begin
            held_nxt[cnt_r[0]] = v;
          end else begin
            job_vld      = 1'b1;
            job.is_line  = 1'b0;
            job.base     = lo16(tb);
            job.ni       = 4'd3;
            if (cnt_r == 2'd2) begin
              p0          = tb;
              p1          = tb + IDX_ONE;
              job.nv      = 3'd3;
              job.vert[0] = held_r[0];
              job.vert[1] = held_r[1];
              job.vert[2] = v;
            end else begin
              job.nv      = 3'd1;
              job.vert[0] = v;
            end
            job.idx[0] = lo16(p0);
            job.idx[1] = lo16(p1);
            ip0_nxt    = p0;
            ip1_nxt    = p1;
            if (mode_r == MODE_FAN) begin
              adv     = p1 + IDX_ONE;
              ip1_nxt = adv;
            end else begin
              // advance the index that trails the other by one
              sel = ((p1 - p0) == IDX_ONE) ? 1'b0 : 1'b1;
              adv = (sel ? p1 : p0) + IDX_TWO;
              if (sel) ip1_nxt = adv;
              else     ip0_nxt = adv;
            end
            job.idx[2]  = lo16(adv);
            tri_tot_nxt = tb + idx_t'(job.nv);
          end
        end else if (mode_r == MODE_LSTRIP) begin
          if (cnt_r == 2'd0) begin
            held_nxt[0] = v;
          end else begin
            job_vld     = 1'b1;
            job.is_line = 1'b1;
            job.base    = lo16(lb);
            job.ni      = 4'd2;
            if (cnt_r == 2'd1) begin
              p0          = lb;
              p1          = lb;
              job.nv      = 3'd2;
              job.vert[0] = held_r[0];
              job.vert[1] = v;
            end else begin
              job.nv      = 3'd1;
              job.vert[0] = v;
            end
            adv          = p0 + IDX_ONE;
            job.idx[0]   = lo16(p0);
            job.idx[1]   = lo16(adv);
            ip0_nxt      = adv;
            ip1_nxt      = p1;
            line_tot_nxt = lb + idx_t'(job.nv);
          end
        end
      end
      CMD_BEGIN_FN: begin
        mode_nxt = MODE_FAN;
        cnt_nxt  = 2'd0;
      end
      CMD_BEGIN_ST: begin
        mode_nxt = MODE_STRIP;
        cnt_nxt  = 2'd0;
      end
      CMD_BEGIN_LS: begin
        mode_nxt = MODE_LSTRIP;
        cnt_nxt  = 2'd0;
      end
      CMD_CLOSE: begin
        mode_nxt = MODE_DEFAULT;
        if (mode_r == MODE_LSTRIP) begin
          job_vld     = 1'b1;
          job.is_line = 1'b1;
          job.ni      = 4'd2;
          job.idx[0]  = lo16(ip0_r);
          job.idx[1]  = lo16(ip1_r);
        end
      end
      CMD_LINE: begin
        mode_nxt     = MODE_DEFAULT;
        job_vld      = 1'b1;
        job.is_line  = 1'b1;
        job.base     = lo16(lb);
        job.nv       = 3'd2;
        job.ni       = 4'd2;
        job.vert[0]  = v;
        job.vert[1]  = '{x: item.x_end, y: item.y_end, colour: c_end};
        job.idx[0]   = lo16(lb);
        job.idx[1]   = lo16(lb + IDX_ONE);
        line_tot_nxt = lb + IDX_TWO;
      end
      CMD_RECT: begin
        mode_nxt    = MODE_DEFAULT;
        job_vld     = 1'b1;
        job.is_line = 1'b1;
        job.base    = lo16(lb);
        job.vert[0] = v;
        if (eqx && eqy) begin
          // point: one vertex, no segment
          job.nv = 3'd1;
        end else if (eqx || eqy) begin
          job.nv      = 3'd2;
          job.ni      = 4'd2;
          job.vert[1] = '{x: item.x_end, y: item.y_end, colour: item.colour};
          job.idx[0]  = lo16(lb);
          job.idx[1]  = lo16(lb + IDX_ONE);
        end else begin
          job.nv      = 3'd4;
          job.ni      = 4'd8;
          job.vert[1] = '{x: item.x_end, y: item.y,     colour: item.colour};
          job.vert[2] = '{x: item.x_end, y: item.y_end, colour: item.colour};
          job.vert[3] = '{x: item.x,     y: item.y_end, colour: item.colour};
          job.idx[0]  = lo16(lb);
          job.idx[1]  = lo16(lb + IDX_ONE);
          job.idx[2]  = lo16(lb + IDX_ONE);
          job.idx[3]  = lo16(lb + IDX_TWO);
          job.idx[4]  = lo16(lb + IDX_TWO);
          job.idx[5]  = lo16(lb + idx_t'(3));
          job.idx[6]  = lo16(lb + idx_t'(3));
          job.idx[7]  = lo16(lb);
        end
        line_tot_nxt = lb + idx_t'(job.nv);
      end
      default: begin
        mode_nxt    = MODE_DEFAULT;
        job_vld     = 1'b1;
        job.is_line = 1'b0;
        job.base    = lo16(tb);
        job.nv      = 3'd4;
        job.ni      = 4'd6;
        job.vert[0] = v;
        job.vert[1] = '{x: xr,     y: item.y, colour: item.colour};
        job.vert[2] = '{x: item.x, y: yb,     colour: item.colour};
        job.vert[3] = '{x: xr,     y: yb,     colour: item.colour};
        job.idx[0]  = lo16(tb);
        job.idx[1]  = lo16(tb + IDX_ONE);
        job.idx[2]  = lo16(tb + IDX_TWO);
        job.idx[3]  = lo16(tb + IDX_ONE);
        job.idx[4]  = lo16(tb + IDX_TWO);
        job.idx[5]  = lo16(tb + idx_t'(3));
        tri_tot_nxt = tb + idx_t'(4);
      end
    endcase

    if (!accept) job_vld = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_DEFAULT;
      cnt_r      <= 2'd0;
      held_r     <= '0;
      ip0_r      <= '0;
      ip1_r      <= '0;
      tri_tot_r  <= '0;
      line_tot_r <= '0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      cnt_r      <= cnt_nxt;
      held_r     <= held_nxt;
      ip0_r      <= ip0_nxt;
      ip1_r      <= ip1_nxt;
      tri_tot_r  <= tri_tot_nxt;
      line_tot_r <= line_tot_nxt;
    end
  end

endmodule

>>> rtl/vspa_jobq.sv
// ----------------------------------------------------------------------------
// vspa_jobq: short job queue between front and back
// Register-based FIFO; the head entry is shown without a read latency.
// ----------------------------------------------------------------------------
module vspa_jobq import vspa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       push_job,
  input  logic       pop,
  output job_t       head,
  output jobq_stat_t stat
);

  job_t [JOBQ_DEPTH-1:0] mem_r;
  logic [JOBQ_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [JOBQ_AW:0]      cnt_r;

  assign stat.full  = (cnt_r == (JOBQ_AW+1)'(JOBQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> rtl/vspa_back.sv
// ----------------------------------------------------------------------------
// vspa_back: record sequencer
// Walks the head job into the output register, one record per cycle while free.
// ----------------------------------------------------------------------------
module vspa_back import vspa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       job,
  input  jobq_stat_t stat,
  output logic       job_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output out_item_t  out_item
);

  logic [3:0]  step_r, step_nxt;
  logic        out_vld_r;
  out_item_t   out_r;

  logic        advance, is_vtx, is_last;
  logic [3:0]  total, k;
  out_item_t   rec;

  assign advance = !stat.empty && (!out_vld_r || out_pop);

  always_comb begin
    total   = 4'(job.nv) + job.ni;
    is_vtx  = (step_r < 4'(job.nv));
    is_last = (step_r == total - 4'd1);
    k       = step_r - 4'(job.nv);
    rec     = '0;
    rec.last = is_last;
    if (is_vtx) begin
      rec.kind        = job.is_line ? KIND_LINE_VTX : KIND_TRI_VTX;
      rec.pos_x       = job.vert[step_r[1:0]].x;
      rec.pos_y       = job.vert[step_r[1:0]].y;
      rec.vert_colour = job.vert[step_r[1:0]].colour;
      rec.index_value = job.base + 16'(step_r);
    end else begin
      rec.kind        = job.is_line ? KIND_LINE_IDX : KIND_TRI_IDX;
      rec.index_value = job.idx[k[2:0]];
    end
    job_pop  = advance && is_last;
    step_nxt = step_r;
    if (advance) step_nxt = is_last ? 4'd0 : step_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (advance) out_r <= rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= 4'd0;
      out_vld_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (advance)      out_vld_r <= 1'b1;
      else if (out_pop) out_vld_r <= 1'b0;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_item  = out_r;

endmodule

>>> rtl/vertex_stream_primitive_assembler_top.sv
// ----------------------------------------------------------------------------
// vertex_stream_primitive_assembler_top: triangle/line primitive assembly
// Turns drawing commands into vertex and index records for two lists.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue-style push port: a command request is taken on a rising
//   edge with in_push high and in_full low. Results come out of a queue-style
//   pop port: the oldest record sits on out_item while out_empty is low and
//   leaves on an edge with out_pop high.
//   A command that causes records yields 1 to 12 of them, in order, with
//   last set on the final one. A taken command's job goes into the job
//   queue, then its first record into the output register. The record
//   sequencer emits one record per cycle while the output register is free
//   or popped; a strip or fan vertex after the first triangle yields four
//   records. Commands without records (begin, held vertices) skip the back end.
//   A two-entry job queue parts command decode from record output: decode
//   keeps taking commands while records wait, and in_full rises only once
//   both queue entries are taken. A stalled record holds on the ports.
//   Reset clears the draw mode, counters, held vertices, indices, list
//   totals, the job queue pointers, the record step and the output valid flag.
// ----------------------------------------------------------------------------
module vertex_stream_primitive_assembler_top import vspa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic       accept, job_vld, job_pop;
  job_t       job_in, job_head;
  jobq_stat_t q_stat;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;

  vspa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_item),
    .job_vld (job_vld),
    .job     (job_in)
  );

  vspa_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_vld),
    .push_job (job_in),
    .pop      (job_pop),
    .head     (job_head),
    .stat     (q_stat)
  );

  vspa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_head),
    .stat      (q_stat),
    .job_pop   (job_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule
